FILE: design/point_in_polygon_parity_assert.svh
// Assertion macros shared by the point-in-polygon checker.
`ifndef POINT_IN_POLYGON_PARITY_ASSERT_SVH
`define POINT_IN_POLYGON_PARITY_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define PIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pip: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off while in reset.
`define PIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pip: next-cycle check failed");

`endif

FILE: design/pip_pkg.sv
// Types and constants of the point-in-polygon parity block.
`default_nettype none

package pip_pkg;

  localparam int unsigned COORD_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH  = 7;
  localparam int unsigned INDEX_WIDTH  = 6;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned MIN_VERTICES = 3;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [COUNT_WIDTH-1:0] VERTEX_COUNT_RESET = 7'd3;

  typedef struct packed {
    logic                          req_type;
    logic [INDEX_WIDTH-1:0]        vertex_index;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } pip_req_t;

  typedef struct packed {
    logic                   inside_res;
    logic [COUNT_WIDTH-1:0] crossing_count;
  } pip_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } pip_state_e;

endpackage

`default_nettype wire

FILE: design/point_in_polygon_parity.sv
// Point-in-polygon test by ray-casting crossing parity over a vertex memory.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): a load beat writes one
// vertex into the vertex memory, gives no result and leaves the input open. A
// query beat walks every edge of the polygon and gives one result beat on
// the output channel (out_valid_o/out_ready_i, out_data_o).
// A query occupies the block until its result is loaded, n being vertex_count
// clamped to [3, MAX_VERTICES]: the single memory read port delivers one vertex
// per cycle (n + 1 reads, the first vertex is read again to close the polygon),
// followed by the difference, multiply and compare stages of the edge test.
// The result becomes valid in the same cycle that the next beat is taken.
// The result sits in an output register, so loads and a further query are
// taken while it waits; a second result waits in the walk control until
// the receiver takes the first one.
// vertex_count is to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Reset returns vertex_count
// to 3 and empties the control; the vertex memory is not cleared, so every
// vertex in use must be loaded first.
`default_nettype none

module point_in_polygon_parity #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  pip_pkg::pip_req_t                      in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output pip_pkg::pip_res_t                      out_data_o,
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [pip_pkg::APB_ADDR_W-1:0]         paddr,
  input  wire  [pip_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [pip_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = 2 * (CW + 1);

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] vertex_count_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RESET;
    end else if (cfg_wr) begin
      vertex_count_q <= pwdata[COUNT_WIDTH-1:0];
    end
  end

  // Read back the register; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata = APB_DATA_W'(vertex_count_q);
    end
  end

  // Clamp the vertex count to the supported range
  logic [NW-1:0] n_clamp;
  always_comb begin
    if (32'(vertex_count_q) < MIN_VERTICES) begin
      n_clamp = NW'(MIN_VERTICES);
    end else if (32'(vertex_count_q) > MAX_VERTICES) begin
      n_clamp = NW'(MAX_VERTICES);
    end else begin
      n_clamp = NW'(vertex_count_q);
    end
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  pip_state_e state_q, state_d;
  logic       in_acc, query_acc, load_acc;
  logic       rd_en, pipe_empty, out_free, res_load;
  logic [NW-1:0] seq_q, n_q;
  logic       rd_vld_q, d_vld_q, m_vld_q, have_prev_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign query_acc = in_acc && (in_data_i.req_type == REQ_QUERY);
  assign load_acc  = in_acc && (in_data_i.req_type == REQ_LOAD)
                     && (32'(in_data_i.vertex_index) < MAX_VERTICES);
  assign pipe_empty = !rd_vld_q && !d_vld_q && !m_vld_q;
  assign out_free   = !out_valid_o || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (seq_q == n_q) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (pipe_empty && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_WALK:  rd_en      = 1'b1;
      ST_FLUSH: res_load   = pipe_empty && out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the read sequence: addresses 0 .. n-1, then 0 again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (query_acc) begin
        seq_q       <= '0;
        have_prev_q <= 1'b0;
      end else begin
        if (rd_en) seq_q <= seq_q + NW'(1);
        if (rd_vld_q) have_prev_q <= 1'b1;
      end
    end
  end

  // Hold the query point and the clamped count
  logic signed [CW-1:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      px_q <= in_data_i.coord_x;
      py_q <= in_data_i.coord_y;
      n_q  <= n_clamp;
    end
  end

  // ---------------------------------------------------------------
  // Vertex memory: {x, y} per entry, one write and one read port
  // ---------------------------------------------------------------
  logic [2*CW-1:0] vert_mem [MAX_VERTICES];
  logic [2*CW-1:0] rd_data_q;
  logic [AW-1:0]   rd_addr;

  assign rd_addr = (seq_q == n_q) ? '0 : seq_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      vert_mem[AW'(in_data_i.vertex_index)] <= {in_data_i.coord_x, in_data_i.coord_y};
    end
    if (rd_en) begin
      rd_data_q <= vert_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------
  // Edge test pipeline
  // ---------------------------------------------------------------
  logic [2*CW-1:0]      prev_q;
  logic signed [CW-1:0] x1, y1, x2, y2;

  assign x1 = prev_q[2*CW-1:CW];
  assign y1 = prev_q[CW-1:0];
  assign x2 = rd_data_q[2*CW-1:CW];
  assign y2 = rd_data_q[CW-1:0];

  // Keep the previous vertex as the start of the next edge
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) prev_q <= rd_data_q;
  end

  // Differences and strict y-span test
  logic signed [CW:0] dx_q, dy_q, t_q, e_q;
  logic               btw_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= rd_vld_q && have_prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= {x2[CW-1], x2} - {x1[CW-1], x1};
    dy_q    <= {y2[CW-1], y2} - {y1[CW-1], y1};
    t_q     <= {py_q[CW-1], py_q} - {y1[CW-1], y1};
    e_q     <= {px_q[CW-1], px_q} - {x1[CW-1], x1};
    btw_d_q <= ((py_q < y1) && (py_q > y2)) || ((py_q < y2) && (py_q > y1));
  end

  // Cross products
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic                 btw_m_q, dy_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q    <= dx_q * t_q;
    rhs_q    <= e_q * dy_q;
    btw_m_q  <= btw_d_q;
    dy_neg_q <= dy_q[CW];
  end

  // Compare and count crossings
  logic          crossed;
  logic [NW-1:0] count_q;

  assign crossed = m_vld_q && btw_m_q && (dy_neg_q ? (rhs_q > lhs_q) : (lhs_q > rhs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (query_acc) begin
      count_q <= '0;
    end else if (crossed) begin
      count_q <= count_q + NW'(1);
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_o.inside_res     <= count_q[0];
      out_data_o.crossing_count <= COUNT_WIDTH'(count_q);
    end
  end

endmodule

`default_nettype wire

FILE: design/pip_checker.sv
// Port-level checker for the point-in-polygon parity block, with its bind.
`default_nettype none
`include "point_in_polygon_parity_assert.svh"

module pip_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input pip_pkg::pip_req_t in_data_i,
  input wire               out_valid_o,
  input wire               out_ready_i
);

  import pip_pkg::*;

  // A query beat keeps the input closed in the next cycle
  `PIP_ASSERT_NEXT(a_query_blocks, in_valid_i && in_ready_o && in_data_i.req_type == REQ_QUERY, !in_ready_o)

  // A load beat leaves the input open for the next beat
  `PIP_ASSERT_NEXT(a_load_keeps_open, in_valid_i && in_ready_o && in_data_i.req_type == REQ_LOAD, in_ready_o)

  // A new result only appears at the end of a walk, while the input is closed
  `PIP_ASSERT_SAME(a_result_after_walk, $rose(out_valid_o), !$past(in_ready_o))

  // A result beat stays until the receiver takes it
  `PIP_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind point_in_polygon_parity pip_checker u_pip_checker (.*);

`default_nettype wire

FILE: verif/tb_point_in_polygon_parity.sv
// Testbench for the point-in-polygon parity block: directed and random beats, scoreboard check.
`timescale 1ns / 1ps

module tb_point_in_polygon_parity;
  import pip_pkg::*;

  localparam int unsigned MAX_VERTS     = 64;
  localparam int unsigned ITEMS_TARGET  = 1300;
  localparam int unsigned IDLE_PERCENT  = 23;
  localparam int unsigned SETTLE_CYCLES = MAX_VERTS + 5;
  localparam int unsigned COUNT_ALL_ONE = (1 << COUNT_WIDTH) - 1;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pip_req_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pip_res_t              out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Polygon shadow of the block and its expected results
  logic signed [COORD_WIDTH-1:0] poly_x [MAX_VERTS];
  logic signed [COORD_WIDTH-1:0] poly_y [MAX_VERTS];
  logic [COUNT_WIDTH-1:0]        vertex_count_q;
  pip_res_t                      pending_parity [$];
  int unsigned                   error_count;
  int unsigned                   items_sent;
  bit                            steady_flow;

  point_in_polygon_parity dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Give up after a generous bound
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Number of vertices walked, clamped to the legal range
  function automatic int unsigned edges_in_use();
    if (vertex_count_q < MIN_VERTICES) return MIN_VERTICES;
    if (vertex_count_q > MAX_VERTS) return MAX_VERTS;
    return vertex_count_q;
  endfunction

  // Count edges crossed by the ray from (qx, qy) toward +x, exact wide math
  function automatic logic [COUNT_WIDTH-1:0] count_crossings(
      input logic signed [COORD_WIDTH-1:0] qx, input logic signed [COORD_WIDTH-1:0] qy);
    int unsigned            n;
    int unsigned            j;
    longint                 x1, y1, x2, y2, px, py;
    logic signed [127:0]    dx, dy, t, e, lhs, rhs;
    logic [COUNT_WIDTH-1:0] hits;
    bit                     crossed;
    n    = edges_in_use();
    hits = '0;
    px   = qx;
    py   = qy;
    for (int unsigned i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      x1 = poly_x[i];
      y1 = poly_y[i];
      x2 = poly_x[j];
      y2 = poly_y[j];
      // skip horizontal edges and edges the ray's y is not strictly inside
      if (y1 == y2) continue;
      if (!((py < y1 && py > y2) || (py < y2 && py > y1))) continue;
      dx  = x2 - x1;
      dy  = y2 - y1;
      t   = py - y1;
      e   = px - x1;
      lhs = dx * t;
      rhs = e * dy;
      crossed = (dy > 0) ? (lhs > rhs) : (rhs > lhs);
      if (crossed) hits = hits + 1'b1;
    end
    return hits;
  endfunction

  // Fold one accepted beat into the shadow polygon or the expected results
  task automatic record_beat(input pip_req_t beat);
    pip_res_t res;
    if (beat.req_type == REQ_LOAD) begin
      poly_x[beat.vertex_index] = beat.coord_x;
      poly_y[beat.vertex_index] = beat.coord_y;
    end else begin
      res.crossing_count = count_crossings(beat.coord_x, beat.coord_y);
      res.inside_res     = res.crossing_count[0];
      pending_parity     = {pending_parity, res};
    end
  endtask

  function automatic pip_req_t load_beat(input int unsigned slot,
      input logic signed [COORD_WIDTH-1:0] x, input logic signed [COORD_WIDTH-1:0] y);
    pip_req_t b;
    b.req_type     = REQ_LOAD;
    b.vertex_index = INDEX_WIDTH'(slot);
    b.coord_x      = x;
    b.coord_y      = y;
    return b;
  endfunction

  function automatic pip_req_t query_beat(input logic signed [COORD_WIDTH-1:0] x,
      input logic signed [COORD_WIDTH-1:0] y);
    pip_req_t b;
    b.req_type     = REQ_QUERY;
    b.vertex_index = INDEX_WIDTH'($urandom_range(0, MAX_VERTS - 1));
    b.coord_x      = x;
    b.coord_y      = y;
    return b;
  endfunction

  // Q16.16 from an integer
  function automatic logic signed [COORD_WIDTH-1:0] fx(input int v);
    return v * 65536;
  endfunction

  // Random coordinate spread over +/- 2^bits
  function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input int unsigned bits);
    int r;
    r = $urandom;
    return r >>> (31 - bits);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_between(input longint lo,
      input longint hi);
    longint unsigned span;
    longint unsigned r;
    span = hi - lo + 1;
    r    = {$urandom, $urandom};
    return COORD_WIDTH'(lo + longint'(r % span));
  endfunction

  // Idle cycles before the next beat, none while flow is steady
  function automatic int unsigned idle_gap();
    int unsigned gap;
    gap = 0;
    if (!steady_flow)
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    return gap;
  endfunction

  // Send one beat and hold it until accepted
  task automatic send_beat(input pip_req_t beat);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    record_beat(beat);
    items_sent++;
  endtask

  // Drop valid, then wait for every expected result and let the block settle
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_parity.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of vertex_count, only with the block idle
  task automatic write_vertex_count(input int unsigned value);
    wait_for_drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({REG_VERTEX_COUNT, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    vertex_count_q = value[COUNT_WIDTH-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Random receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    pip_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_parity.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_data_o.crossing_count, 0);
      end else begin
        want = pending_parity.pop_front();
        if (out_data_o.inside_res !== want.inside_res)
          report_mismatch("inside_res", out_data_o.inside_res, want.inside_res);
        if (out_data_o.crossing_count !== want.crossing_count)
          report_mismatch("crossing_count", out_data_o.crossing_count, want.crossing_count);
      end
    end
  end

  // Load slots 0..n-1, sometimes in reverse, with a horizontal edge now and then
  task automatic load_polygon(input int unsigned n, input int unsigned bits);
    int unsigned                   slot;
    bit                            backwards;
    logic signed [COORD_WIDTH-1:0] vx, vy;
    backwards = $urandom_range(0, 1);
    vy        = '0;
    for (int unsigned k = 0; k < n; k++) begin
      slot = backwards ? n - 1 - k : k;
      vx   = rand_coord(bits);
      if (k == 0 || $urandom_range(0, 9) != 0) vy = rand_coord(bits);
      send_beat(load_beat(slot, vx, vy));
    end
  endtask

  // Query points around the current polygon, with a stray load now and then
  task automatic query_polygon(input int unsigned count);
    int unsigned                   n, a, b, pick;
    longint                        lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_WIDTH-1:0] qx, qy;
    n    = edges_in_use();
    lo_x = poly_x[0];
    hi_x = poly_x[0];
    lo_y = poly_y[0];
    hi_y = poly_y[0];
    for (int unsigned i = 1; i < n; i++) begin
      if (poly_x[i] < lo_x) lo_x = poly_x[i];
      if (poly_x[i] > hi_x) hi_x = poly_x[i];
      if (poly_y[i] < lo_y) lo_y = poly_y[i];
      if (poly_y[i] > hi_y) hi_y = poly_y[i];
    end
    for (int unsigned q = 0; q < count; q++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(load_beat($urandom_range(0, MAX_VERTS - 1), $urandom, $urandom));
      a    = $urandom_range(0, n - 1);
      b    = (a + 1 == n) ? 0 : a + 1;
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        qx = rand_between(lo_x, hi_x);
        qy = rand_between(lo_y, hi_y);
      end else if (pick <= 6) begin
        // ray through a vertex
        qx = rand_between(lo_x, hi_x);
        qy = poly_y[a];
      end else if (pick == 7) begin
        qx = poly_x[a];
        qy = poly_y[a];
      end else if (pick == 8) begin
        // point on an edge
        qx = COORD_WIDTH'((longint'(poly_x[a]) + longint'(poly_x[b])) >>> 1);
        qy = COORD_WIDTH'((longint'(poly_y[a]) + longint'(poly_y[b])) >>> 1);
      end else begin
        qx = $urandom;
        qy = $urandom;
      end
      send_beat(query_beat(qx, qy));
    end
  endtask

  // Right triangle at reset count: inside, outside, vertex, horizontal edge, on edge
  task automatic test_triangle_basics();
    send_beat(load_beat(0, fx(0), fx(0)));
    send_beat(load_beat(1, fx(10), fx(0)));
    send_beat(load_beat(2, fx(0), fx(10)));
    send_beat(query_beat(fx(2), fx(2)));
    send_beat(query_beat(fx(-5), fx(2)));
    send_beat(query_beat(fx(20), fx(2)));
    send_beat(query_beat(fx(2), fx(0)));
    send_beat(query_beat(fx(-1), fx(10)));
    send_beat(query_beat(fx(5), fx(5)));
  endtask

  // Counts below three clamp up, then grow to a quadrilateral
  task automatic test_count_clamp();
    write_vertex_count(0);
    send_beat(query_beat(fx(-5), fx(3)));
    write_vertex_count(2);
    send_beat(query_beat(fx(1), fx(1)));
    send_beat(load_beat(3, fx(-3), fx(7)));
    write_vertex_count(4);
    send_beat(query_beat(fx(-4), fx(3)));
    send_beat(query_beat(fx(1), fx(8)));
  endtask

  // Full-scale vertices and query points, last slot loaded too
  task automatic test_extreme_coords();
    write_vertex_count(MIN_VERTICES);
    send_beat(load_beat(0, COORD_MIN, COORD_MIN));
    send_beat(load_beat(1, COORD_MAX, fx(0)));
    send_beat(load_beat(2, COORD_MIN, COORD_MAX));
    send_beat(load_beat(MAX_VERTS - 1, COORD_MAX, COORD_MIN));
    send_beat(query_beat(COORD_MIN, fx(0)));
    send_beat(query_beat(fx(0), fx(0)));
    send_beat(query_beat(COORD_MAX, -1));
    send_beat(query_beat(COORD_MIN + 1, COORD_MAX - 1));
  endtask

  // Largest polygon, reached through an over-range count and the exact limit
  task automatic test_max_vertices();
    write_vertex_count(COUNT_ALL_ONE);
    load_polygon(MAX_VERTS, 24);
    query_polygon(6);
    write_vertex_count(MAX_VERTS);
    query_polygon(4);
  endtask

  // Random polygons of mostly small size; each new count drains the block first
  task automatic test_random_polygons();
    int unsigned n, pick, bits, poly_idx;
    poly_idx = 0;
    while (items_sent < ITEMS_TARGET) begin
      steady_flow = (poly_idx >= 15 && poly_idx < 25);
      pick = $urandom_range(0, 99);
      if (pick < 65) n = $urandom_range(MIN_VERTICES, 8);
      else if (pick < 93) n = $urandom_range(9, 24);
      else n = $urandom_range(25, MAX_VERTS);
      if (n == MIN_VERTICES && $urandom_range(0, 1))
        write_vertex_count($urandom_range(0, MIN_VERTICES));
      else if (n == MAX_VERTS && $urandom_range(0, 1))
        write_vertex_count($urandom_range(MAX_VERTS, COUNT_ALL_ONE));
      else
        write_vertex_count(n);
      bits = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(4, 30);
      load_polygon(n, bits);
      query_polygon($urandom_range(2, 10));
      poly_idx++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady_flow    = 1'b0;
    vertex_count_q = VERTEX_COUNT_RESET;
    error_count    = 0;
    items_sent     = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_triangle_basics();
    test_count_clamp();
    test_extreme_coords();
    test_max_vertices();
    test_random_polygons();

    wait_for_drain();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
